[design/gcni_pkg.sv]
// Package: payload structs, status codes and configuration register indices for the grid cell neighbor index.
`timescale 1ns / 1ps
package gcni_pkg;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_OUT  = 2'd2;

  localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] REG_CELL_SIZE = 3'd2;
  localparam logic [2:0] REG_CELLS_X   = 3'd3;
  localparam logic [2:0] REG_CELLS_Y   = 3'd4;

  typedef struct packed {
    logic               mode;
    logic        [15:0] point_id;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] neighbor_id;
    logic        id_valid;
    logic [1:0]  status;
    logic        last;
  } out_beat_t;

endpackage

[design/grid_cell_neighbor_index.sv]
// Top level: uniform grid spatial index with insert and 3x3 neighbor query.
`timescale 1ns / 1ps
// The block takes one input beat at a time on in_valid/in_stall and answers
// on out_valid/out_stall. An insert gives one status beat; a query gives one
// beat per id stored in the 3x3 block of cells, with last on the final beat,
// or a single empty beat when no id is found.
// Each axis index comes from a restoring divider that retires one quotient
// bit a cycle. The x division runs first, then the y division, and the range
// check follows in S_CHECK; a point outside the grid is answered from that
// state. For an insert the fill count then comes back and, if the cell has
// room, is written back, then the status beat is loaded. A query visits each
// neighbor cell in S_CELL, S_FILL and S_SLOT (S_CELL and S_FILL alone for one
// outside the grid), emits one id per cycle while the output does not stall,
// and closes in S_CELL and S_OUT, bounded by the single read port of the slot
// memory. The next input beat is taken the cycle after the final output beat
// of an item is loaded; input is stalled until then. After reset a clearing
// pass zeroes the fill memory, one cell a cycle, over all GRID_X*GRID_Y cells;
// input is stalled during it, configuration writes are taken. When the receiver
// stalls, the output beat holds in its register and the sequencer waits; no
// beat is lost. Configuration is written only while idle or clearing.
module grid_cell_neighbor_index #(
  parameter int GRID_X        = 64,
  parameter int GRID_Y        = 64,
  parameter int CELL_CAPACITY = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  gcni_pkg::in_beat_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output gcni_pkg::out_beat_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import gcni_pkg::*;

  localparam int XW    = (GRID_X > 1) ? $clog2(GRID_X) : 1;
  localparam int YW    = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
  localparam int NC    = GRID_X * GRID_Y;
  localparam int CW    = (NC > 1) ? $clog2(NC) : 1;
  localparam int NS    = NC * CELL_CAPACITY;
  localparam int SW    = (NS > 1) ? $clog2(NS) : 1;
  localparam int LW    = 11;
  localparam logic [LW-1:0] GX = LW'(GRID_X);
  localparam logic [LW-1:0] GY = LW'(GRID_Y);
  localparam logic [2:0] CAP = 3'(CELL_CAPACITY);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIVX  = 4'd2;
  localparam logic [3:0] S_DIVY  = 4'd3;
  localparam logic [3:0] S_CHECK = 4'd4;
  localparam logic [3:0] S_IRD   = 4'd5;
  localparam logic [3:0] S_IWR   = 4'd6;
  localparam logic [3:0] S_CELL  = 4'd7;
  localparam logic [3:0] S_FILL  = 4'd8;
  localparam logic [3:0] S_SLOT  = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic signed [31:0] origin_x, origin_y;
  logic [30:0] cell_size;
  logic [6:0]  cells_x, cells_y;

  logic [3:0]  state;
  logic [CW-1:0] clr_addr;
  in_beat_t    item;

  // Divider: dividend d (33 bit, signed) plus cs-1, divided by cs.
  logic [33:0] div_num;
  logic [33:0] div_rem;
  logic [5:0]  div_cnt;
  logic        neg_x, neg_y;
  logic [33:0] qx, qy;
  logic [33:0] qx_m1, qy_m1;
  logic        off_grid;

  logic [LW-1:0] lim_x, lim_y;
  logic [XW-1:0] ix;
  logic [YW-1:0] iy;

  // Query walk: column 0..2 is x+1, x-1, x; row 0..2 is y, y-1, y+1.
  logic [1:0]  nb_col, nb_row;
  logic [1:0]  nb_col_next, nb_row_next;
  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  logic        nb_ok;
  logic [2:0]  fill_q;
  logic [2:0]  slot;
  logic [2:0]  slot_rd;
  logic        have_pend;
  logic [15:0] pend_id;
  logic [1:0]  ins_status;

  logic        out_free, out_load, emit_go;
  out_beat_t   out_next;

  logic [2:0]  fill_mem [NC];
  logic [15:0] slot_mem [NS];
  logic [CW-1:0] fill_raddr, fill_waddr;
  logic [2:0]  fill_rdata, fill_wdata;
  logic        fill_we;
  logic [SW-1:0] slot_raddr;
  logic [15:0] slot_rdata;
  logic        slot_we;
  logic [SW-1:0] slot_waddr;

  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
    fill_rdata <= fill_mem[fill_raddr];
  end
  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= item.point_id;
    slot_rdata <= slot_mem[slot_raddr];
  end

  assign cfg_ready = (state == S_IDLE) || (state == S_CLEAR);
  assign in_stall  = (state != S_IDLE);

  // The output register can take a new beat when empty or when its beat leaves.
  assign out_free = !out_valid || !out_stall;
  assign emit_go  = (state == S_EMIT) && (!have_pend || out_free);

  always_comb begin
    lim_x = (LW'(cells_x) > GX) ? GX : LW'(cells_x);
    lim_y = (LW'(cells_y) > GY) ? GY : LW'(cells_y);
  end

  function automatic logic [33:0] start_num(input logic signed [31:0] c,
                                            input logic signed [31:0] o,
                                            input logic [30:0] cs);
    logic signed [32:0] d;
    d = 33'(c) - 33'(o);
    return 34'(d) + 34'(cs) - 34'd1;
  endfunction

  function automatic logic neg_of(input logic signed [31:0] c,
                                  input logic signed [31:0] o);
    logic signed [32:0] d;
    d = 33'(c) - 33'(o);
    return d[32];
  endfunction

  logic [30:0] cs_eff;
  assign cs_eff = (cell_size == '0) ? 31'd1 : cell_size;

  logic [34:0] trial;
  assign trial = {div_rem, div_num[33]} - 35'(cs_eff);

  // The quotient is ceil(d/cs); the cell index is one less, floored at zero.
  assign qx_m1    = (qx == '0) ? '0 : qx - 34'd1;
  assign qy_m1    = (qy == '0) ? '0 : qy - 34'd1;
  assign off_grid = neg_x || neg_y || (qx_m1 >= 34'(lim_x)) || (qy_m1 >= 34'(lim_y));
  assign ix = XW'(qx_m1);
  assign iy = YW'(qy_m1);

  logic signed [11:0] ncx, ncy;
  always_comb begin
    case (nb_col)
      2'd0:    ncx = $signed(12'(ix)) + 12'sd1;
      2'd1:    ncx = $signed(12'(ix)) - 12'sd1;
      default: ncx = $signed(12'(ix));
    endcase
    case (nb_row)
      2'd0:    ncy = $signed(12'(iy));
      2'd1:    ncy = $signed(12'(iy)) - 12'sd1;
      default: ncy = $signed(12'(iy)) + 12'sd1;
    endcase
  end

  always_comb begin
    if (nb_row == 2'd2) begin
      nb_row_next = 2'd0;
      nb_col_next = nb_col + 2'd1;
    end else begin
      nb_row_next = nb_row + 2'd1;
      nb_col_next = nb_col;
    end
  end

  logic [CW-1:0] cur_cell;
  assign cur_cell = CW'(32'(cx) * GRID_Y + 32'(cy));
  logic [CW-1:0] home_cell;
  assign home_cell = CW'(32'(ix) * GRID_Y + 32'(iy));

  // The slot read runs one id ahead while beats go out, so each id arrives
  // in the cycle it is needed.
  assign slot_rd = (emit_go && (slot + 3'd1 != fill_q)) ? slot + 3'd1 : slot;

  always_comb begin
    fill_raddr = (state == S_CHECK) ? home_cell : cur_cell;
    fill_we    = (state == S_CLEAR);
    fill_waddr = clr_addr;
    fill_wdata = '0;
    slot_we    = 1'b0;
    slot_waddr = SW'(32'(home_cell) * CELL_CAPACITY + 32'(fill_rdata));
    slot_raddr = SW'(32'(cur_cell) * CELL_CAPACITY + 32'(slot_rd));
    if (state == S_IRD && fill_rdata < CAP) begin
      fill_we    = 1'b1;
      fill_waddr = home_cell;
      fill_wdata = fill_rdata + 3'd1;
      slot_we    = 1'b1;
    end
  end

  always_comb begin
    out_load = 1'b0;
    out_next = '0;
    unique case (state)
      S_CHECK: if (off_grid) begin
        out_load = out_free;
        out_next = '{16'd0, 1'b0, STATUS_OUT, 1'b1};
      end
      S_IWR: begin
        out_load = out_free;
        out_next = '{16'd0, 1'b0, ins_status, 1'b1};
      end
      S_EMIT: if (have_pend) begin
        out_load = out_free;
        out_next = '{pend_id, 1'b1, STATUS_OK, 1'b0};
      end
      S_OUT: begin
        out_load = out_free;
        out_next = '{have_pend ? pend_id : 16'd0, have_pend, STATUS_OK, 1'b1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x  <= '0;
      origin_y  <= '0;
      cell_size <= 31'd98304;
      cells_x   <= 7'd64;
      cells_y   <= 7'd64;
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      have_pend <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ORIGIN_X:  origin_x  <= cfg_data;
          REG_ORIGIN_Y:  origin_y  <= cfg_data;
          REG_CELL_SIZE: cell_size <= cfg_data[30:0];
          REG_CELLS_X:   cells_x   <= cfg_data[6:0];
          REG_CELLS_Y:   cells_y   <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_data  <= out_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == CW'(NC - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          item    <= in_data;
          neg_x   <= neg_of(in_data.coord_x, origin_x);
          neg_y   <= neg_of(in_data.coord_y, origin_y);
          div_num <= start_num(in_data.coord_x, origin_x, cs_eff);
          div_rem <= '0;
          div_cnt <= '0;
          state   <= S_DIVX;
        end
        S_DIVX, S_DIVY: begin
          if (div_cnt != 6'd33) begin
            div_rem <= !trial[34] ? trial[33:0] : {div_rem[32:0], div_num[33]};
            div_num <= {div_num[32:0], !trial[34]};
            div_cnt <= div_cnt + 6'd1;
          end else begin
            div_rem <= '0;
            div_cnt <= '0;
            if (state == S_DIVX) begin
              qx      <= {div_num[32:0], !trial[34]};
              div_num <= start_num(item.coord_y, origin_y, cs_eff);
              state   <= S_DIVY;
            end else begin
              qy    <= {div_num[32:0], !trial[34]};
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          // The fill count of the home cell is read here for an insert.
          if (off_grid) begin
            if (out_free) state <= S_IDLE;
          end else if (item.mode == 1'b0) begin
            state <= S_IRD;
          end else begin
            nb_col    <= '0;
            nb_row    <= '0;
            have_pend <= 1'b0;
            state     <= S_CELL;
          end
        end
        S_IRD: begin
          ins_status <= (fill_rdata < CAP) ? STATUS_OK : STATUS_FULL;
          state      <= S_IWR;
        end
        S_IWR: if (out_free) state <= S_IDLE;
        S_CELL: begin
          if (nb_col == 2'd3) begin
            state <= S_OUT;
          end else begin
            nb_ok <= (ncx >= 12'sd0) && (ncx < $signed(12'(lim_x))) &&
                     (ncy >= 12'sd0) && (ncy < $signed(12'(lim_y)));
            cx    <= XW'(ncx);
            cy    <= YW'(ncy);
            state <= S_FILL;
          end
        end
        S_FILL: begin
          // fill read issued for cur_cell this cycle
          if (!nb_ok) begin
            nb_col <= nb_col_next;
            nb_row <= nb_row_next;
            state  <= S_CELL;
          end else begin
            slot  <= '0;
            state <= S_SLOT;
          end
        end
        S_SLOT: begin
          fill_q <= (fill_rdata > CAP) ? CAP : fill_rdata;
          if (fill_rdata == '0) begin
            nb_col <= nb_col_next;
            nb_row <= nb_row_next;
            state  <= S_CELL;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: if (emit_go) begin
          // One id is held back so that the final one can carry last.
          pend_id   <= slot_rdata;
          have_pend <= 1'b1;
          slot      <= slot + 3'd1;
          if (slot + 3'd1 == fill_q) begin
            nb_col <= nb_col_next;
            nb_row <= nb_row_next;
            state  <= S_CELL;
          end
        end
        S_OUT: if (out_free) begin
          have_pend <= 1'b0;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
